// File: sv/mse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants of the merge sort engine
// Holds the controller state type and the fixed widths of the word fields.
// ----------------------------------------------------------------------------
package mse_pkg;

    // Width of the value and sorted_value fields on the ports.
    localparam int unsigned VALUE_W = 32;

    typedef enum logic [4:0] {
        ST_LOAD      = 5'b00001,
        ST_SORT      = 5'b00010,
        ST_EMIT_RD   = 5'b00100,
        ST_EMIT_LD   = 5'b01000,
        ST_EMIT_HOLD = 5'b10000
    } state_t;

endpackage
`default_nettype wire

// File: sv/merge_sort_engine_unit.sv
`default_nettype none
// Flow: words are loaded into buffer A until one arrives with is_last. After the last word
// the list of n words is sorted in ceil(log2 n) merge passes, with one result written
// per cycle into the destination buffer once each pass is primed.
// Emission reads the first word in ST_EMIT_RD, then moves each word through ST_EMIT_LD
// and ST_EMIT_HOLD while result_stall holds it. No input is taken while sorting or emitting.
// Reset clears control state only; the buffers are undefined until written.
// ----------------------------------------------------------------------------
// merge_sort_engine_unit: stable bottom-up merge sort over ping-pong buffers
// Collects a list of signed words, sorts it ascending with equal words kept in
// arrival order, and emits it with an end marker and an overflow flag.
// ----------------------------------------------------------------------------
module merge_sort_engine_unit #(
    parameter int unsigned MAX_ITEMS  = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic signed [mse_pkg::VALUE_W-1:0]  value,
    input  wire logic                                is_last,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic signed [mse_pkg::VALUE_W-1:0]       sorted_value,
    output logic                                     end_of_list,
    output logic                                     overflow
);

    localparam int unsigned AW    = $clog2(MAX_ITEMS);
    localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
    localparam int unsigned WW    = CW + 1;
    localparam int unsigned IW    = CW + 2;
    localparam int unsigned EXT_W = (DATA_WIDTH > mse_pkg::VALUE_W) ? DATA_WIDTH
                                                                    : mse_pkg::VALUE_W;

    // Ping-pong buffers with registered read data on two ports each.
    logic [DATA_WIDTH-1:0] buf_a_reg [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] buf_b_reg [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;

    logic                  wr_a, wr_b;
    logic [AW-1:0]         wr_addr, rd0_addr, rd1_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    mse_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            dropped_reg, dropped_next;
    logic [CW-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0]   mid_reg, mid_next, hi_reg, hi_next, e_reg, e_next;
    logic [WW-1:0]   width_reg, width_next;
    logic            src_b_reg, src_b_next;
    logic            primed_reg, primed_next;

    logic                    res_valid_reg, res_valid_next;
    logic [DATA_WIDTH-1:0]   res_data_reg, res_data_next;
    logic                    res_eol_reg, res_eol_next;
    logic                    res_ovf_reg, res_ovf_next;

    logic signed [EXT_W-1:0] value_ext;
    logic [EXT_W-1:0]        res_ext;
    logic [DATA_WIDTH-1:0]   left_word, right_word;
    logic                    take_left;
    logic [CW-1:0]           i_inc, j_inc, k_inc, count_inc;
    logic [IW-1:0]           n_w, pair_mid_w, pair_hi_w, pass_w_w, pass_hi_w;
    logic [WW-1:0]           width_dbl;

    function automatic logic [AW-1:0] e_inc_addr(input logic [CW-1:0] e);
        logic [CW-1:0] nxt;
        nxt = e + CW'(1);
        return nxt[AW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            buf_a_reg[wr_addr] <= wr_data;
        end
        if (wr_b)
        begin
            buf_b_reg[wr_addr] <= wr_data;
        end
        rd_a0_reg <= buf_a_reg[rd0_addr];
        rd_a1_reg <= buf_a_reg[rd1_addr];
        rd_b0_reg <= buf_b_reg[rd0_addr];
        rd_b1_reg <= buf_b_reg[rd1_addr];
    end

    assign value_ext  = EXT_W'(value);
    assign left_word  = src_b_reg ? rd_b0_reg : rd_a0_reg;
    assign right_word = src_b_reg ? rd_b1_reg : rd_a1_reg;
    // The left run wins ties, which keeps the sort stable.
    assign take_left  = (i_reg < mid_reg) &&
                        ((j_reg >= hi_reg) || ($signed(left_word) <= $signed(right_word)));

    assign i_inc      = i_reg + CW'(take_left);
    assign j_inc      = j_reg + CW'(!take_left);
    assign k_inc      = k_reg + CW'(1);
    assign count_inc  = count_reg + CW'(1);
    assign n_w        = IW'(count_reg);
    assign pair_mid_w = IW'(hi_reg) + IW'(width_reg);
    assign pair_hi_w  = IW'(hi_reg) + (IW'(width_reg) << 1);
    assign width_dbl  = width_reg << 1;
    assign pass_w_w   = IW'(width_dbl);
    assign pass_hi_w  = IW'(width_dbl) << 1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        e_next         = e_reg;
        width_next     = width_reg;
        src_b_next     = src_b_reg;
        primed_next    = primed_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        res_eol_next   = res_eol_reg;
        res_ovf_next   = res_ovf_reg;
        wr_a           = 1'b0;
        wr_b           = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = value_ext[DATA_WIDTH-1:0];
        rd0_addr       = i_reg[AW-1:0];
        rd1_addr       = j_reg[AW-1:0];

        unique case (state_reg)
            mse_pkg::ST_LOAD:
            begin
                if (item_valid)
                begin
                    if (count_reg == CW'(MAX_ITEMS))
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        wr_a       = 1'b1;
                        count_next = count_inc;
                    end
                    if (is_last)
                    begin
                        src_b_next  = 1'b0;
                        e_next      = '0;
                        width_next  = WW'(1);
                        i_next      = '0;
                        j_next      = CW'(1);
                        mid_next    = CW'(1);
                        hi_next     = CW'(2);
                        k_next      = '0;
                        primed_next = 1'b0;
                        if (count_next == CW'(1))
                        begin
                            state_next = mse_pkg::ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = mse_pkg::ST_SORT;
                        end
                    end
                end
            end

            mse_pkg::ST_SORT:
            begin
                if (!primed_reg)
                begin
                    primed_next = 1'b1;
                end
                else
                begin
                    wr_a     = src_b_reg;
                    wr_b     = !src_b_reg;
                    wr_addr  = k_reg[AW-1:0];
                    wr_data  = take_left ? left_word : right_word;
                    i_next   = i_inc;
                    j_next   = j_inc;
                    k_next   = k_inc;
                    rd0_addr = i_inc[AW-1:0];
                    rd1_addr = j_inc[AW-1:0];
                    if (k_inc == hi_reg)
                    begin
                        if (hi_reg == count_reg)
                        begin
                            // Pass complete: swap buffers and double the run width.
                            src_b_next  = !src_b_reg;
                            width_next  = width_dbl;
                            primed_next = 1'b0;
                            i_next      = '0;
                            k_next      = '0;
                            mid_next    = (pass_w_w > n_w) ? count_reg : pass_w_w[CW-1:0];
                            j_next      = (pass_w_w > n_w) ? count_reg : pass_w_w[CW-1:0];
                            hi_next     = (pass_hi_w > n_w) ? count_reg : pass_hi_w[CW-1:0];
                            if (pass_w_w >= n_w)
                            begin
                                state_next = mse_pkg::ST_EMIT_RD;
                            end
                        end
                        else
                        begin
                            // Next pair of runs in the same pass, no bubble.
                            i_next   = hi_reg;
                            k_next   = hi_reg;
                            mid_next = (pair_mid_w > n_w) ? count_reg : pair_mid_w[CW-1:0];
                            j_next   = (pair_mid_w > n_w) ? count_reg : pair_mid_w[CW-1:0];
                            hi_next  = (pair_hi_w > n_w) ? count_reg : pair_hi_w[CW-1:0];
                            rd0_addr = hi_reg[AW-1:0];
                            rd1_addr = (pair_mid_w > n_w) ? count_reg[AW-1:0]
                                                          : pair_mid_w[AW-1:0];
                        end
                    end
                end
            end

            mse_pkg::ST_EMIT_RD:
            begin
                rd0_addr   = e_reg[AW-1:0];
                state_next = mse_pkg::ST_EMIT_LD;
            end

            mse_pkg::ST_EMIT_LD:
            begin
                rd0_addr       = e_reg[AW-1:0];
                res_valid_next = 1'b1;
                res_data_next  = src_b_reg ? rd_b0_reg : rd_a0_reg;
                res_eol_next   = ((e_reg + CW'(1)) == count_reg);
                res_ovf_next   = dropped_reg;
                state_next     = mse_pkg::ST_EMIT_HOLD;
            end

            mse_pkg::ST_EMIT_HOLD:
            begin
                rd0_addr = e_inc_addr(e_reg);
                if (!result_stall)
                begin
                    res_valid_next = 1'b0;
                    if (res_eol_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = mse_pkg::ST_LOAD;
                    end
                    else
                    begin
                        e_next     = e_reg + CW'(1);
                        state_next = mse_pkg::ST_EMIT_LD;
                    end
                end
            end

            default:
            begin
                state_next = mse_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mse_pkg::ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            e_reg         <= '0;
            width_reg     <= '0;
            src_b_reg     <= 1'b0;
            primed_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            e_reg         <= e_next;
            width_reg     <= width_next;
            src_b_reg     <= src_b_next;
            primed_reg    <= primed_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        res_eol_reg  <= res_eol_next;
        res_ovf_reg  <= res_ovf_next;
    end

    assign res_ext      = EXT_W'(res_data_reg);
    assign item_stall   = (state_reg != mse_pkg::ST_LOAD);
    assign result_valid = res_valid_reg;
    assign sorted_value = res_ext[mse_pkg::VALUE_W-1:0];
    assign end_of_list  = res_eol_reg;
    assign overflow     = res_ovf_reg;

`ifndef SYNTHESIS
    a_no_load_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("input taken while a result word is pending");

    a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mse_pkg::ST_SORT) |->
            (i_reg <= mid_reg && mid_reg <= hi_reg && hi_reg <= count_reg))
        else $error("merge run bounds out of order");

    a_write_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mse_pkg::ST_SORT) |-> (k_reg < hi_reg))
        else $error("merge write index beyond run pair");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("element count above capacity");

    a_end_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && end_of_list) |=>
            (state_reg == mse_pkg::ST_LOAD && count_reg == '0 && !dropped_reg))
        else $error("list end did not clear count and flag");
`endif

endmodule
`default_nettype wire
